// File: hdl/ptp_pkg.sv
// Shared types and constants for the priority thread picker.
// Used by ptp_ctrl, ptp_datapath and priority_thread_picker; no dependencies.
package ptp_pkg;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_UPDATE = 2'd3
    } cmd_code_t;

    localparam int PADDR_W = 3;
    // value of the word index bit of paddr that selects schedule_enable
    localparam logic REG_IDX_ENABLE = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic latch_item;
        logic tick_inc;
        logic first_pick;
        logic rd_cur;
        logic wr_last_cur;
        logic cap_cur;
        logic idx_clear;
        logic idx_inc;
        logic add_write;
        logic set_fail;
        logic slot_edit;
        logic scan_eval;
        logic pass_inc;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      cur_valid;
        logic      out_free;
        logic      idx_free;
        logic      idx_last;
        logic      scan_last;
    } dp_stat_t;

endpackage

// File: hdl/ptp_ctrl.sv
// Sequencing state machine of the priority thread picker.
// Depends on ptp_pkg; drives ptp_datapath through dp_cmd_t.
module ptp_ctrl
    import ptp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     sched_en,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_EXEC      = 6'b000010,
        ST_ADD_SCAN  = 6'b000100,
        ST_PASS_LOAD = 6'b001000,
        ST_PASS_SCAN = 6'b010000,
        ST_DONE      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (stat.cmd)
                    CMD_TICK: begin
                        cmd.tick_inc = 1'b1;
                        if (sched_en && stat.cur_valid) begin
                            // stamp current slot, fetch its fields
                            cmd.rd_cur      = 1'b1;
                            cmd.wr_last_cur = 1'b1;
                            cmd.idx_clear   = 1'b1;
                            state_next      = ST_PASS_LOAD;
                        end else begin
                            cmd.first_pick = sched_en;
                            state_next     = ST_DONE;
                        end
                    end
                    CMD_ADD: begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_ADD_SCAN;
                    end
                    CMD_REMOVE, CMD_UPDATE: begin
                        cmd.slot_edit = 1'b1;
                        state_next    = ST_DONE;
                    end
                endcase
            end
            ST_ADD_SCAN: begin
                if (stat.idx_free) begin
                    cmd.add_write = 1'b1;
                    state_next    = ST_DONE;
                end else if (stat.idx_last) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_PASS_LOAD: begin
                cmd.cap_cur = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = ST_PASS_SCAN;
            end
            ST_PASS_SCAN: begin
                // evaluate slot read last cycle, fetch the next one
                cmd.scan_eval = 1'b1;
                cmd.idx_inc   = 1'b1;
                if (stat.scan_last) begin
                    cmd.pass_inc = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/ptp_datapath.sv
// Slot table, counters, current-thread registers and result register.
// Depends on ptp_pkg; controlled by ptp_ctrl.
module ptp_datapath
    import ptp_pkg::*;
#(
    parameter int MAX_THREADS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  s_command,
    input  logic [2:0]  s_slot,
    input  logic [7:0]  s_priority_req,
    input  logic        s_ready_req,
    input  logic [63:0] s_wake_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [2:0]  m_given_slot,
    output logic        m_current_valid,
    output logic [2:0]  m_current_slot,
    output logic [63:0] m_time_now
);

    localparam int IDXW = $clog2(MAX_THREADS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_THREADS - 1);

    typedef struct packed {
        logic        rdy;
        logic [7:0]  prio;
        logic [63:0] wake;
    } attr_t;

    // latched item
    cmd_code_t   cmd_reg;
    logic [2:0]  slot_reg;
    logic [7:0]  prio_reg;
    logic        rdy_reg;
    logic [63:0] wake_reg;

    logic [MAX_THREADS-1:0] used_reg;
    logic [MAX_THREADS-1:0] written_reg;
    attr_t       attr_mem [MAX_THREADS];
    logic [63:0] last_mem [MAX_THREADS];

    logic [63:0]     tick_reg, pass_reg;
    logic [IDXW-1:0] cur_slot_reg;
    logic            cur_valid_reg;
    logic [7:0]      cur_prio_reg;
    logic [63:0]     cur_wake_reg, cur_last_reg;
    logic [IDXW-1:0] idx_reg;

    attr_t           attr_rd_reg;
    logic [63:0]     last_rd_reg;
    logic [IDXW-1:0] rd_slot_reg;
    logic            rd_written_reg, rd_used_reg;

    logic            status_reg;
    logic [2:0]      given_reg;

    logic            m_valid_reg, m_status_reg, m_cur_valid_reg;
    logic [2:0]      m_given_reg, m_cur_slot_reg;
    logic [63:0]     m_time_reg;

    logic [IDXW-1:0] slot_idx, rd_addr, attr_wa, last_wa;
    logic            slot_ok, attr_we, last_we;
    attr_t           attr_wd, attr_rd;
    logic [63:0]     last_wd;
    logic            cand, prio_ok, cur_sleeps, older, take;

    assign slot_idx = IDXW'(slot_reg);
    assign slot_ok  = (32'(slot_reg) < 32'(MAX_THREADS)) && used_reg[slot_idx];
    assign rd_addr  = cmd.rd_cur ? cur_slot_reg : idx_reg;

    // attribute write port: add at scan index, update at item slot
    assign attr_we = cmd.add_write ||
                     (cmd.slot_edit && slot_ok && (cmd_reg == CMD_UPDATE));
    assign attr_wa = cmd.add_write ? idx_reg : slot_idx;
    assign attr_wd = '{rdy: rdy_reg, prio: prio_reg, wake: wake_reg};

    assign last_we = cmd.add_write || cmd.wr_last_cur;
    assign last_wa = cmd.add_write ? idx_reg : cur_slot_reg;
    assign last_wd = cmd.add_write ? 64'd0 : pass_reg;

    always_ff @(posedge aclk) begin
        if (attr_we) begin
            attr_mem[attr_wa] <= attr_wd;
        end
        attr_rd_reg <= attr_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (last_we) begin
            last_mem[last_wa] <= last_wd;
        end
        last_rd_reg <= last_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        rd_slot_reg    <= rd_addr;
        rd_written_reg <= written_reg[rd_addr];
        rd_used_reg    <= used_reg[rd_addr];
    end

    // never-written entries read as their reset value
    assign attr_rd    = rd_written_reg ? attr_rd_reg : '0;
    assign cand       = rd_used_reg && attr_rd.rdy && (attr_rd.wake <= tick_reg);
    assign prio_ok    = attr_rd.prio >= cur_prio_reg;
    assign cur_sleeps = cur_wake_reg >= tick_reg;
    assign older      = last_rd_reg < cur_last_reg;
    assign take       = cmd.scan_eval && cand && (prio_ok || cur_sleeps) && older;

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            cmd_reg  <= cmd_code_t'(s_command);
            slot_reg <= s_slot;
            prio_reg <= s_priority_req;
            rdy_reg  <= s_ready_req;
            wake_reg <= s_wake_time;
        end
        if (cmd.cap_cur) begin
            cur_prio_reg <= attr_rd.prio;
            cur_wake_reg <= attr_rd.wake;
            cur_last_reg <= pass_reg;
        end else if (take) begin
            cur_prio_reg <= attr_rd.prio;
            cur_wake_reg <= attr_rd.wake;
            cur_last_reg <= last_rd_reg;
        end
        if (cmd.idx_clear) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc && (idx_reg != LAST_IDX)) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.latch_item) begin
            status_reg <= 1'b0;
            given_reg  <= 3'd0;
        end else if (cmd.set_fail || (cmd.slot_edit && !slot_ok)) begin
            status_reg <= 1'b1;
        end else if (cmd.add_write) begin
            given_reg <= 3'(idx_reg);
        end
        if (cmd.out_load) begin
            m_status_reg    <= status_reg;
            m_given_reg     <= given_reg;
            m_cur_valid_reg <= cur_valid_reg;
            m_cur_slot_reg  <= 3'(cur_slot_reg);
            m_time_reg      <= tick_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            written_reg   <= '0;
            tick_reg      <= '0;
            pass_reg      <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.add_write) begin
                used_reg[idx_reg]    <= 1'b1;
                written_reg[idx_reg] <= 1'b1;
            end else if (cmd.slot_edit && slot_ok) begin
                if (cmd_reg == CMD_REMOVE) begin
                    used_reg[slot_idx] <= 1'b0;
                end else begin
                    written_reg[slot_idx] <= 1'b1;
                end
            end
            if (cmd.tick_inc) begin
                tick_reg <= tick_reg + 64'd1;
            end
            if (cmd.first_pick || cmd.pass_inc) begin
                pass_reg <= pass_reg + 64'd1;
            end
            if (cmd.first_pick) begin
                cur_slot_reg  <= '0;
                cur_valid_reg <= 1'b1;
            end else if (take) begin
                cur_slot_reg <= rd_slot_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.cur_valid = cur_valid_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.idx_free  = !used_reg[idx_reg];
    assign stat.idx_last  = (idx_reg == LAST_IDX);
    assign stat.scan_last = (rd_slot_reg == LAST_IDX);

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_given_slot    = m_given_reg;
    assign m_current_valid = m_cur_valid_reg;
    assign m_current_slot  = m_cur_slot_reg;
    assign m_time_now      = m_time_reg;

endmodule

// File: hdl/priority_thread_picker.sv
// Priority thread picker: one item in, one item out, one item at a time.
// Tick without scheduling, remove and update run through EXEC and DONE; add scans slots
// from index 0 up to the first free slot (the whole table when it is full); a tick with a
// selection pass scans every slot, one slot read per cycle from the slot table memory. The next item is taken
// once the result leaves. Reset (aresetn low, synchronous) clears slot valid bits,
// counters, current thread and schedule_enable; table entries never written read as zero.
module priority_thread_picker
    import ptp_pkg::*;
#(
    parameter int MAX_THREADS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // command items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [2:0]         s_slot,
    input  logic [7:0]         s_priority_req,
    input  logic               s_ready_req,
    input  logic [63:0]        s_wake_time,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [2:0]         m_given_slot,
    output logic               m_current_valid,
    output logic [2:0]         m_current_slot,
    output logic [63:0]        m_time_now
);

    logic     sched_en_reg;
    logic     reg_sel;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign reg_sel = (paddr[2] == REG_IDX_ENABLE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'd0, sched_en_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_en_reg <= 1'b0;
        end else if (psel && penable && pwrite && reg_sel) begin
            sched_en_reg <= pwdata[0];
        end
    end

    ptp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .sched_en (sched_en_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptp_datapath #(
        .MAX_THREADS (MAX_THREADS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_command       (s_command),
        .s_slot          (s_slot),
        .s_priority_req  (s_priority_req),
        .s_ready_req     (s_ready_req),
        .s_wake_time     (s_wake_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_given_slot    (m_given_slot),
        .m_current_valid (m_current_valid),
        .m_current_slot  (m_current_slot),
        .m_time_now      (m_time_now)
    );

    // an accepted item finds the result register empty in the next cycle
    a_out_empty_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("result register not empty after item accept");

    // once chosen, a current thread never goes away
    a_cur_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(stat.cur_valid) |-> stat.cur_valid)
        else $error("current thread valid dropped");

    // a failed command reports no slot
    a_fail_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_given_slot == 3'd0))
        else $error("failed item reports a given slot");

endmodule

// File: test/thread_picker_monitor.sv
`timescale 1ns / 100ps
// Watches the config, command and result channels of priority_thread_picker,
// predicts every result item and compares it. Depends on ptp_pkg.
module thread_picker_monitor
    import ptp_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [2:0]         s_slot,
    input  logic [7:0]         s_priority_req,
    input  logic               s_ready_req,
    input  logic [63:0]        s_wake_time,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_status,
    input  logic [2:0]         m_given_slot,
    input  logic               m_current_valid,
    input  logic [2:0]         m_current_slot,
    input  logic [63:0]        m_time_now,
    output int                 error_count,
    output int                 pending
);

    typedef struct packed {
        logic        status;
        logic [2:0]  given;
        logic        cur_valid;
        logic [2:0]  cur_slot;
        logic [63:0] now;
    } pick_result_t;

    // thread table mirror
    logic        thr_used  [SLOTS];
    logic        thr_ready [SLOTS];
    logic [7:0]  thr_prio  [SLOTS];
    logic [63:0] thr_wake  [SLOTS];
    logic [63:0] thr_last  [SLOTS];
    logic [63:0] ticks;
    logic [63:0] passes;
    logic [2:0]  run_slot;
    logic        run_valid;
    logic        sched_en;

    pick_result_t predicted_results[$];
    pick_result_t want;
    pick_result_t fresh;

    initial error_count = 0;
    initial pending = 0;

    task automatic flag(input string msg);
        error_count++;
        $display("%0t thread_picker_monitor: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want_v);
        if (got !== want_v)
            flag($sformatf("%s got %0h, expected %0h", name, got, want_v));
    endtask

    // one selection pass, run after the tick increment
    task automatic pick_thread();
        if (!run_valid) begin
            run_slot = '0;
            run_valid = 1'b1;
        end else begin
            thr_last[run_slot] = passes;
            for (int i = 0; i < SLOTS; i++) begin
                if (thr_used[i] && thr_ready[i] && thr_wake[i] <= ticks) begin
                    // compared against the current slot as it stands mid-scan
                    if ((thr_prio[i] >= thr_prio[run_slot] || thr_wake[run_slot] >= ticks)
                            && thr_last[i] < thr_last[run_slot])
                        run_slot = i[2:0];
                end
            end
        end
        passes++;
    endtask

    task automatic step_thread_table(input cmd_code_t cmd, input logic [2:0] sl,
                                     input logic [7:0] pr, input logic rq,
                                     input logic [63:0] wk, output pick_result_t res);
        logic found;
        res = '0;
        found = 1'b0;
        case (cmd)
            CMD_TICK: begin
                ticks++;
                if (sched_en)
                    pick_thread();
            end
            CMD_ADD: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && !thr_used[i]) begin
                        found = 1'b1;
                        thr_used[i]  = 1'b1;
                        thr_ready[i] = rq;
                        thr_prio[i]  = pr;
                        thr_wake[i]  = wk;
                        thr_last[i]  = '0;
                        res.given    = i[2:0];
                    end
                end
                res.status = !found;
            end
            default: begin
                if (int'(sl) >= SLOTS || !thr_used[sl]) begin
                    res.status = 1'b1;
                end else if (cmd == CMD_REMOVE) begin
                    thr_used[sl] = 1'b0;
                end else begin
                    thr_ready[sl] = rq;
                    thr_prio[sl]  = pr;
                    thr_wake[sl]  = wk;
                end
            end
        endcase
        res.cur_valid = run_valid;
        res.cur_slot  = run_slot;
        res.now       = ticks;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                thr_used[i]  = 1'b0;
                thr_ready[i] = 1'b0;
                thr_prio[i]  = '0;
                thr_wake[i]  = '0;
                thr_last[i]  = '0;
            end
            ticks     = '0;
            passes    = '0;
            run_slot  = '0;
            run_valid = 1'b0;
            sched_en  = 1'b0;
            predicted_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_IDX_ENABLE)
                sched_en = pwdata[0];
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    flag("result item with none expected");
                end else begin
                    want = predicted_results.pop_front();
                    check_field("status", m_status, want.status);
                    check_field("given_slot", m_given_slot, want.given);
                    check_field("current_valid", m_current_valid, want.cur_valid);
                    check_field("current_slot", m_current_slot, want.cur_slot);
                    check_field("time_now", m_time_now, want.now);
                end
            end
            if (s_valid && s_ready) begin
                step_thread_table(cmd_code_t'(s_command), s_slot, s_priority_req,
                                  s_ready_req, s_wake_time, fresh);
                predicted_results.push_back(fresh);
            end
        end
        pending = predicted_results.size();
    end

endmodule

// File: test/tb_priority_thread_picker.sv
`timescale 1ns / 100ps
// Testbench top for priority_thread_picker: clock, reset, APB writes and
// command stimulus; checking is done in thread_picker_monitor. Depends on ptp_pkg.
module tb_priority_thread_picker;
    import ptp_pkg::*;

    localparam int SLOTS = 8;
    localparam logic [63:0] ALL_ONES = '1;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cmd_code_t          s_command = CMD_TICK;
    logic [2:0]         s_slot = '0;
    logic [7:0]         s_priority_req = '0;
    logic               s_ready_req = 1'b0;
    logic [63:0]        s_wake_time = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_status;
    logic [2:0]         m_given_slot;
    logic               m_current_valid;
    logic [2:0]         m_current_slot;
    logic [63:0]        m_time_now;

    int          error_count;
    int          pending;
    logic [63:0] ticks_sent = '0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    int          rx_hold = 0;

    always #10 aclk = ~aclk;

    priority_thread_picker #(.MAX_THREADS(SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command), .s_slot(s_slot),
        .s_priority_req(s_priority_req), .s_ready_req(s_ready_req),
        .s_wake_time(s_wake_time),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_given_slot(m_given_slot), .m_current_valid(m_current_valid),
        .m_current_slot(m_current_slot), .m_time_now(m_time_now)
    );

    thread_picker_monitor #(.SLOTS(SLOTS)) monitor (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command), .s_slot(s_slot),
        .s_priority_req(s_priority_req), .s_ready_req(s_ready_req),
        .s_wake_time(s_wake_time),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_given_slot(m_given_slot), .m_current_valid(m_current_valid),
        .m_current_slot(m_current_slot), .m_time_now(m_time_now),
        .error_count(error_count), .pending(pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
            if (rx_gaps_on && $urandom_range(0, 2) == 0)
                rx_hold = pick_gap();
        end
    end

    task automatic set_sched_enable(input logic en);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IDX_ENABLE, 2'b00};
        pwdata  <= {31'b0, en};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input cmd_code_t c, input logic [2:0] sl, input logic [7:0] pr,
                             input logic rq, input logic [63:0] wk);
        s_valid        <= 1'b1;
        s_command      <= c;
        s_slot         <= sl;
        s_priority_req <= pr;
        s_ready_req    <= rq;
        s_wake_time    <= wk;
        do @(posedge aclk); while (!s_ready);
        if (c == CMD_TICK)
            ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // wait for every outstanding result, plus room for the longest pass
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
        repeat (SLOTS + 12) @(negedge aclk);
    endtask

    function automatic logic [63:0] pick_wake();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 64'($urandom_range(0, 4)) + ticks_sent - 64'(ticks_sent > 4 ? 4 : 0);
        if (r < 75) return ticks_sent + 64'($urandom_range(1, 20));
        if (r < 85) return '0;
        if (r < 95) return {$urandom, $urandom};
        return ALL_ONES;
    endfunction

    task automatic random_items(input int count);
        cmd_code_t   c;
        logic [7:0]  pr;
        int          r;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                tx_gaps_on = $urandom_range(0, 3) != 0;
                rx_gaps_on = $urandom_range(0, 3) != 0;
            end
            r = $urandom_range(0, 99);
            if (r < 35)      c = CMD_TICK;
            else if (r < 55) c = CMD_ADD;
            else if (r < 70) c = CMD_REMOVE;
            else             c = CMD_UPDATE;
            // narrow priorities make ties common
            pr = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
            send_item(c, 3'($urandom_range(0, 7)), pr, $urandom_range(0, 9) < 8, pick_wake());
            hold_off(tx_gaps_on ? pick_gap() : 0);
            if (n == count / 2)
                settle();
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_sched_enable(1'b0);

        // table edits with scheduling off
        send_item(CMD_TICK,   3'd0, 8'd0,   1'b0, '0);
        send_item(CMD_ADD,    3'd0, 8'd255, 1'b1, '0);
        send_item(CMD_ADD,    3'd7, 8'd0,   1'b0, ALL_ONES);
        send_item(CMD_ADD,    3'd0, 8'd5,   1'b1, 64'd0);
        hold_off(3);
        send_item(CMD_ADD,    3'd0, 8'd5,   1'b1, 64'd1);
        send_item(CMD_ADD,    3'd0, 8'd200, 1'b1, 64'd2);
        send_item(CMD_ADD,    3'd0, 8'd1,   1'b1, 64'd0);
        send_item(CMD_ADD,    3'd0, 8'd5,   1'b1, 64'h8000_0000_0000_0000);
        send_item(CMD_ADD,    3'd0, 8'd128, 1'b1, 64'd0);
        send_item(CMD_ADD,    3'd0, 8'd9,   1'b1, 64'd0);     // table full
        send_item(CMD_REMOVE, 3'd3, 8'd0,   1'b0, '0);
        send_item(CMD_REMOVE, 3'd3, 8'd0,   1'b0, '0);        // already empty
        send_item(CMD_UPDATE, 3'd3, 8'd7,   1'b1, 64'd0);     // empty slot
        send_item(CMD_UPDATE, 3'd1, 8'd255, 1'b1, 64'd0);
        send_item(CMD_ADD,    3'd0, 8'd5,   1'b1, 64'd3);     // refills slot 3
        settle();
        set_sched_enable(1'b1);

        // first pass takes slot 0, later passes rotate
        send_item(CMD_TICK,   3'd0, 8'd0,   1'b0, '0);
        send_item(CMD_TICK,   3'd0, 8'd0,   1'b0, '0);
        send_item(CMD_REMOVE, 3'd0, 8'd0,   1'b0, '0);        // current slot stays current
        send_item(CMD_TICK,   3'd0, 8'd0,   1'b0, '0);
        send_item(CMD_UPDATE, 3'd2, 8'd5,   1'b0, 64'd0);
        send_item(CMD_UPDATE, 3'd6, 8'd255, 1'b1, ALL_ONES);
        send_item(CMD_TICK,   3'd0, 8'd0,   1'b0, '0);
        send_item(CMD_TICK,   3'd0, 8'd0,   1'b0, '0);
        send_item(CMD_TICK,   3'd0, 8'd0,   1'b0, '0);
        settle();

        random_items(600);
        settle();
        set_sched_enable(1'b0);
        random_items(200);
        settle();
        set_sched_enable(1'b1);
        random_items(500);
        settle();

        if (error_count == 0)
            $display("tb_priority_thread_picker: clean");
        else
            $display("tb_priority_thread_picker: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_priority_thread_picker: errors");
        $finish;
    end

endmodule
